### hw/rtl/hci_efr_pkg.sv
// Package for the HCI event frame receiver: word types, register indexes,
// protocol constants and the result builder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hci_efr_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic [15:0] byte_index;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] frame_length;
    } out_word_t;

    typedef struct packed {
        logic [15:0] buffer_size;
        logic [7:0]  bad_byte_limit;
        logic [3:0]  error_attempts;
    } cfg_t;

    typedef enum logic [1:0] {
        CFG_BUFFER_SIZE    = 2'd0,
        CFG_BAD_BYTE_LIMIT = 2'd1,
        CFG_ERROR_ATTEMPTS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CMD_OK    = 3'd0,
        ST_FLASH_OK  = 3'd1,
        ST_ERR_RESP  = 3'd2,
        ST_NO_HEADER = 3'd3,
        ST_FAILED    = 3'd4
    } status_t;

    typedef enum logic [6:0] {
        PH_HUNT      = 7'b0000001,
        PH_EVENT     = 7'b0000010,
        PH_LENGTH    = 7'b0000100,
        PH_ERR_PAY   = 7'b0001000,
        PH_CMD_PAY   = 7'b0010000,
        PH_FLASH_HDR = 7'b0100000,
        PH_FLASH_PAY = 7'b1000000
    } phase_t;

    localparam logic [15:0] BUFFER_SIZE_RST    = 16'd1024;
    localparam logic [7:0]  BAD_BYTE_LIMIT_RST = 8'd50;
    localparam logic [3:0]  ERROR_ATTEMPTS_RST = 4'd3;

    localparam logic [7:0]  HEADER_BYTE     = 8'h04;
    localparam logic [7:0]  EVT_ERROR       = 8'h10;
    localparam logic [7:0]  LEN_FLASH       = 8'hff;
    localparam logic [7:0]  FLASH_CMD_BYTE  = 8'hf4;
    localparam logic [15:0] FLASH_HDR_BYTES = 16'd6;
    localparam logic [15:0] IDX_FLASH_CMD   = 16'd6;
    localparam logic [15:0] IDX_LEN_LOW     = 16'd7;
    localparam logic [15:0] IDX_LEN_HIGH    = 16'd8;
    localparam logic [16:0] CMD_HDR_LEN     = 17'd3;
    localparam logic [16:0] FLASH_HDR_LEN   = 17'd9;

    function automatic out_word_t make_result(
        input logic        valid,
        input logic [7:0]  b,
        input logic [15:0] idx,
        input logic        done,
        input status_t     st,
        input logic [15:0] flen
    );
        out_word_t r;
        r.byte_valid   = valid;
        r.out_byte     = valid ? b : 8'd0;
        r.byte_index   = valid ? idx : 16'd0;
        r.done_res     = done;
        r.status       = done ? st : ST_CMD_OK;
        r.frame_length = flen;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hci_event_frame_receiver_core.sv
// HCI event frame receiver, top level: configuration registers, the
// per-byte parser and the output buffer.
// Depends on hci_efr_pkg, hci_efr_parser and hci_efr_out_buf.
//
// The input channel carries one UART event per word: a received byte, or a
// read timeout when func is set. The output channel carries at most one
// result word per input word: a stored frame byte with its index, and on
// the last word of a read attempt done_res with a status and, for a good
// frame, the frame length. Events that cause no result (tolerated bad bytes
// while hunting) are absorbed silently.
// A result is registered in the output buffer before it is shown, and one
// input word can be taken every cycle while the buffer is not full; the
// per-byte parser forms the result and its next state combinationally.
// A two-word output buffer sits between parser and output: in_stall rises
// only when both words are held, so a receiver stall reaches the input only
// once the skid register has taken a word as well.
// Reset empties the output buffer, starts hunting for a header and loads the
// registers with buffer_size 1024, bad_byte_limit 50 and error_attempts 3.
// The user writes registers through cfg_we, cfg_index and cfg_data while
// block is idle, not enforced by the block; unused indexes are ignored.
`default_nettype none

module hci_event_frame_receiver_core (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire hci_efr_pkg::in_word_t  in_data,
    output logic                        out_valid,
    input  wire                         out_stall,
    output hci_efr_pkg::out_word_t      out_data,
    input  wire                         cfg_we,
    input  wire [1:0]                   cfg_index,
    input  wire [15:0]                  cfg_data
);
    import hci_efr_pkg::*;

    cfg_t      cfg_reg;
    logic      accept;
    logic      res_valid;
    out_word_t res;
    logic      buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_size    <= BUFFER_SIZE_RST;
            cfg_reg.bad_byte_limit <= BAD_BYTE_LIMIT_RST;
            cfg_reg.error_attempts <= ERROR_ATTEMPTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUFFER_SIZE:    cfg_reg.buffer_size    <= cfg_data;
                CFG_BAD_BYTE_LIMIT: cfg_reg.bad_byte_limit <= cfg_data[7:0];
                CFG_ERROR_ATTEMPTS: cfg_reg.error_attempts <= cfg_data[3:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    hci_efr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_word   (in_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    hci_efr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### hw/rtl/hci_efr_parser.sv
// Per-byte frame parser: holds the frame state and forms at most one result
// word for each accepted input word.
// Depends on hci_efr_pkg.
`default_nettype none

module hci_efr_parser (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         accept,
    input  wire hci_efr_pkg::in_word_t  in_word,
    input  wire hci_efr_pkg::cfg_t      cfg,
    output logic                        res_valid,
    output hci_efr_pkg::out_word_t      res
);
    import hci_efr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] write_index_reg, write_index_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  bad_count_reg, bad_count_next;
    logic [3:0]  error_count_reg, error_count_next;
    logic [7:0]  event_code_reg, event_code_next;
    logic [7:0]  flash_command_reg, flash_command_next;
    logic [7:0]  length_low_reg, length_low_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] idx;
        logic [15:0] idx_inc;
        logic [3:0]  err_inc;
        logic [15:0] flash_len;
        logic        is_err;
        logic        restart_att;
        logic        end_att;

        b           = in_word.rx_byte;
        idx         = write_index_reg;
        idx_inc     = write_index_reg + 16'd1;
        err_inc     = error_count_reg + 4'd1;
        flash_len   = {b, length_low_reg};
        is_err      = (event_code_reg == EVT_ERROR);
        restart_att = 1'b0;
        end_att     = 1'b0;

        phase_next         = phase_reg;
        write_index_next   = write_index_reg;
        bytes_left_next    = bytes_left_reg;
        bad_count_next     = bad_count_reg;
        error_count_next   = error_count_reg;
        event_code_next    = event_code_reg;
        flash_command_next = flash_command_reg;
        length_low_next    = length_low_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (accept)
        begin
            if (phase_reg == PH_HUNT)
            begin
                if (!in_word.func && b == HEADER_BYTE)
                begin
                    res_valid        = 1'b1;
                    res              = make_result(1'b1, b, 16'd0, 1'b0, ST_CMD_OK, 16'd0);
                    write_index_next = 16'd1;
                    phase_next       = PH_EVENT;
                end
                else if (bad_count_reg >= cfg.bad_byte_limit)
                begin
                    res_valid = 1'b1;
                    res       = make_result(1'b0, b, idx, 1'b1, ST_NO_HEADER, 16'd0);
                    end_att   = 1'b1;
                end
                else
                begin
                    bad_count_next = bad_count_reg + 8'd1;
                end
            end
            else if (in_word.func)
            begin
                res_valid = 1'b1;
                res       = make_result(1'b0, b, idx, 1'b1, ST_FAILED, 16'd0);
                end_att   = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_EVENT:
                    begin
                        event_code_next  = b;
                        res_valid        = 1'b1;
                        res              = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK, 16'd0);
                        write_index_next = idx_inc;
                        phase_next       = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        res_valid = 1'b1;
                        if (is_err || b != LEN_FLASH)
                        begin
                            if ({9'd0, b} + CMD_HDR_LEN > {1'b0, cfg.buffer_size})
                            begin
                                res     = make_result(1'b0, b, idx, 1'b1, ST_FAILED, 16'd0);
                                end_att = 1'b1;
                            end
                            else if (b == 8'd0)
                            begin
                                if (is_err)
                                begin
                                    error_count_next = err_inc;
                                    if (err_inc >= cfg.error_attempts)
                                    begin
                                        res     = make_result(1'b1, b, idx, 1'b1, ST_ERR_RESP,
                                                              16'd0);
                                        end_att = 1'b1;
                                    end
                                    else
                                    begin
                                        res         = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK,
                                                                  16'd0);
                                        restart_att = 1'b1;
                                    end
                                end
                                else
                                begin
                                    res     = make_result(1'b1, b, idx, 1'b1, ST_CMD_OK, idx_inc);
                                    end_att = 1'b1;
                                end
                            end
                            else
                            begin
                                bytes_left_next  = {8'd0, b};
                                phase_next       = is_err ? PH_ERR_PAY : PH_CMD_PAY;
                                res              = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK,
                                                               16'd0);
                                write_index_next = idx_inc;
                            end
                        end
                        else
                        begin
                            bytes_left_next  = FLASH_HDR_BYTES;
                            phase_next       = PH_FLASH_HDR;
                            res              = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK, 16'd0);
                            write_index_next = idx_inc;
                        end
                    end
                    PH_FLASH_HDR:
                    begin
                        res_valid = 1'b1;
                        if (idx == IDX_FLASH_CMD)
                        begin
                            flash_command_next = b;
                        end
                        if (idx == IDX_LEN_LOW)
                        begin
                            length_low_next = b;
                        end
                        if (idx >= IDX_LEN_HIGH)
                        begin
                            if (flash_command_reg != FLASH_CMD_BYTE ||
                                {1'b0, flash_len} + FLASH_HDR_LEN > {1'b0, cfg.buffer_size})
                            begin
                                res     = make_result(1'b0, b, idx, 1'b1, ST_FAILED, 16'd0);
                                end_att = 1'b1;
                            end
                            else if (flash_len == 16'd0)
                            begin
                                res     = make_result(1'b1, b, idx, 1'b1, ST_FLASH_OK, idx_inc);
                                end_att = 1'b1;
                            end
                            else
                            begin
                                bytes_left_next  = flash_len;
                                phase_next       = PH_FLASH_PAY;
                                res              = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK,
                                                               16'd0);
                                write_index_next = idx_inc;
                            end
                        end
                        else
                        begin
                            res              = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK, 16'd0);
                            write_index_next = idx_inc;
                        end
                    end
                    PH_ERR_PAY, PH_CMD_PAY, PH_FLASH_PAY:
                    begin
                        res_valid = 1'b1;
                        if (bytes_left_reg <= 16'd1)
                        begin
                            if (phase_reg == PH_ERR_PAY)
                            begin
                                error_count_next = err_inc;
                                if (err_inc >= cfg.error_attempts)
                                begin
                                    res     = make_result(1'b1, b, idx, 1'b1, ST_ERR_RESP, 16'd0);
                                    end_att = 1'b1;
                                end
                                else
                                begin
                                    res         = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK,
                                                              16'd0);
                                    restart_att = 1'b1;
                                end
                            end
                            else
                            begin
                                res     = make_result(1'b1, b, idx, 1'b1,
                                                      (phase_reg == PH_FLASH_PAY) ?
                                                      ST_FLASH_OK : ST_CMD_OK, idx_inc);
                                end_att = 1'b1;
                            end
                        end
                        else
                        begin
                            bytes_left_next  = bytes_left_reg - 16'd1;
                            res              = make_result(1'b1, b, idx, 1'b0, ST_CMD_OK, 16'd0);
                            write_index_next = idx_inc;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end

        if (restart_att || end_att)
        begin
            phase_next         = PH_HUNT;
            write_index_next   = 16'd0;
            bytes_left_next    = 16'd0;
            bad_count_next     = 8'd0;
            event_code_next    = 8'd0;
            flash_command_next = 8'd0;
            length_low_next    = 8'd0;
        end
        if (end_att)
        begin
            error_count_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            write_index_reg   <= 16'd0;
            bytes_left_reg    <= 16'd0;
            bad_count_reg     <= 8'd0;
            error_count_reg   <= 4'd0;
            event_code_reg    <= 8'd0;
            flash_command_reg <= 8'd0;
            length_low_reg    <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            write_index_reg   <= write_index_next;
            bytes_left_reg    <= bytes_left_next;
            bad_count_reg     <= bad_count_next;
            error_count_reg   <= error_count_next;
            event_code_reg    <= event_code_next;
            flash_command_reg <= flash_command_next;
            length_low_reg    <= length_low_next;
        end
    end

    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> (write_index_reg == 16'd0 && bytes_left_reg == 16'd0))
        else $error("Write index or byte count left over while hunting.");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR_PAY || phase_reg == PH_CMD_PAY || phase_reg == PH_FLASH_PAY)
        |-> bytes_left_reg != 16'd0)
        else $error("Payload phase entered with no bytes left.");

    a_flash_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FLASH_HDR |-> (write_index_reg >= 16'd3 && write_index_reg <= 16'd8))
        else $error("Flash header index out of range.");

    a_error_count: assert property (@(posedge clk) disable iff (!rst_n)
        error_count_reg != 4'hf)
        else $error("Error response count overran.");

endmodule

`default_nettype wire

### hw/rtl/hci_efr_out_buf.sv
// Two-deep result buffer: an output register and a skid register, so that a
// stalled receiver does not hold up the parser until both are full.
// Depends on hci_efr_pkg.
`default_nettype none

module hci_efr_out_buf (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         res_valid,
    input  wire hci_efr_pkg::out_word_t res,
    output logic                        full,
    output logic                        out_valid,
    input  wire                         out_stall,
    output hci_efr_pkg::out_word_t      out_data
);
    import hci_efr_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t out_data_reg, out_data_next;
    out_word_t skid_data_reg, skid_data_next;
    logic      out_take;

    assign out_take  = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !out_take)
        begin
            if (res_valid)
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a word while the output register is empty.");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && res_valid))
        else $error("Skid register filled without a stalled output word.");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the HCI event frame receiver core.
// Feeds UART byte and timeout words and checks every result word against a
// built-in frame parser model. Depends on hci_efr_pkg and the core RTL.

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hci_efr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    // Model copy of the registers and of the parser state.
    logic [15:0] cap_bytes;
    logic [7:0]  hunt_limit;
    logic [3:0]  err_limit;
    phase_t      prs_phase;
    logic [15:0] wr_idx;
    logic [15:0] left_cnt;
    logic [7:0]  bad_cnt;
    logic [3:0]  err_cnt;
    logic [7:0]  evt_code;
    logic [7:0]  fl_cmd;
    logic [7:0]  len_lo;

    out_word_t   expected_results[$];
    in_word_t    pending_words[$];

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned words_in = 0;
    int unsigned words_out = 0;
    int unsigned attempts_done = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;

    hci_event_frame_receiver_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic out_word_t word_of(input bit valid, input logic [7:0] b,
                                          input logic [15:0] idx, input bit done,
                                          input status_t st, input logic [15:0] flen);
        out_word_t r;
        r.byte_valid   = valid;
        r.out_byte     = valid ? b : 8'd0;
        r.byte_index   = valid ? idx : 16'd0;
        r.done_res     = done;
        r.status       = done ? st : ST_CMD_OK;
        r.frame_length = flen;
        return r;
    endfunction

    function automatic void restart_frame();
        prs_phase = PH_HUNT;
        wr_idx    = 16'd0;
        left_cnt  = 16'd0;
        bad_cnt   = 8'd0;
        evt_code  = 8'd0;
        fl_cmd    = 8'd0;
        len_lo    = 8'd0;
    endfunction

    function automatic void end_read();
        restart_frame();
        err_cnt = 4'd0;
    endfunction

    function automatic out_word_t fail_read();
        end_read();
        return word_of(1'b0, 8'd0, 16'd0, 1'b1, ST_FAILED, 16'd0);
    endfunction

    function automatic out_word_t finish_error(input logic [7:0] b, input logic [15:0] idx);
        out_word_t r;
        err_cnt = err_cnt + 4'd1;
        if (err_cnt >= err_limit)
        begin
            r = word_of(1'b1, b, idx, 1'b1, ST_ERR_RESP, 16'd0);
            end_read();
        end
        else
        begin
            r = word_of(1'b1, b, idx, 1'b0, ST_CMD_OK, 16'd0);
            restart_frame();
        end
        return r;
    endfunction

    function automatic out_word_t finish_good(input logic [7:0] b, input logic [15:0] idx,
                                              input status_t st);
        end_read();
        return word_of(1'b1, b, idx, 1'b1, st, idx + 16'd1);
    endfunction

    // Advances the model by one accepted word; returns 1 when a result is due.
    function automatic bit parse_event(input in_word_t w, output out_word_t r);
        logic [15:0] idx;
        logic [7:0]  b;
        logic [15:0] n;
        idx = wr_idx;
        b   = w.rx_byte;
        r   = '0;
        if (prs_phase == PH_HUNT)
        begin
            if (!w.func && b == HEADER_BYTE)
            begin
                r = word_of(1'b1, b, 16'd0, 1'b0, ST_CMD_OK, 16'd0);
                wr_idx = 16'd1;
                prs_phase = PH_EVENT;
                return 1'b1;
            end
            if (bad_cnt >= hunt_limit)
            begin
                r = word_of(1'b0, 8'd0, 16'd0, 1'b1, ST_NO_HEADER, 16'd0);
                end_read();
                return 1'b1;
            end
            bad_cnt = bad_cnt + 8'd1;
            return 1'b0;
        end
        if (w.func)
        begin
            r = fail_read();
            return 1'b1;
        end
        case (prs_phase)
            PH_EVENT:
            begin
                evt_code = b;
                prs_phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                if (evt_code == EVT_ERROR || b != LEN_FLASH)
                begin
                    if (17'd3 + {9'd0, b} > {1'b0, cap_bytes})
                    begin
                        r = fail_read();
                        return 1'b1;
                    end
                    if (b == 8'd0)
                    begin
                        r = (evt_code == EVT_ERROR) ? finish_error(b, idx)
                                                    : finish_good(b, idx, ST_CMD_OK);
                        return 1'b1;
                    end
                    left_cnt = {8'd0, b};
                    prs_phase = (evt_code == EVT_ERROR) ? PH_ERR_PAY : PH_CMD_PAY;
                end
                else
                begin
                    left_cnt = 16'd6;
                    prs_phase = PH_FLASH_HDR;
                end
            end
            PH_FLASH_HDR:
            begin
                if (idx == 16'd6)
                    fl_cmd = b;
                if (idx == 16'd7)
                    len_lo = b;
                if (idx >= 16'd8)
                begin
                    n = {b, len_lo};
                    if (fl_cmd != FLASH_CMD_BYTE || 17'd9 + {1'b0, n} > {1'b0, cap_bytes})
                    begin
                        r = fail_read();
                        return 1'b1;
                    end
                    if (n == 16'd0)
                    begin
                        r = finish_good(b, idx, ST_FLASH_OK);
                        return 1'b1;
                    end
                    left_cnt = n;
                    prs_phase = PH_FLASH_PAY;
                end
            end
            default:
            begin
                if (left_cnt <= 16'd1)
                begin
                    if (prs_phase == PH_ERR_PAY)
                        r = finish_error(b, idx);
                    else
                        r = finish_good(b, idx,
                                        (prs_phase == PH_FLASH_PAY) ? ST_FLASH_OK : ST_CMD_OK);
                    return 1'b1;
                end
                left_cnt = left_cnt - 16'd1;
            end
        endcase
        r = word_of(1'b1, b, idx, 1'b0, ST_CMD_OK, 16'd0);
        wr_idx = idx + 16'd1;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        out_word_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            words_in++;
            if (parse_event(in_data, r))
                expected_results.push_back(r);
        end
    end

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            words_out++;
            if (out_data.done_res)
                attempts_done++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("byte_valid", e.byte_valid, out_data.byte_valid);
                check_field("out_byte", e.out_byte, out_data.out_byte);
                check_field("byte_index", e.byte_index, out_data.byte_index);
                check_field("done_res", e.done_res, out_data.done_res);
                check_field("status", e.status, out_data.status);
                check_field("frame_length", e.frame_length, out_data.frame_length);
            end
        end
    end

    // Starts and ends at a falling edge; in_valid stays high after acceptance.
    task automatic send_word(input in_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= in_word_t'($urandom);
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pending();
        while (pending_words.size() != 0)
            send_word(pending_words.pop_front());
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic end_phase();
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_BUFFER_SIZE:    cap_bytes  = val;
            CFG_BAD_BYTE_LIMIT: hunt_limit = val[7:0];
            CFG_ERROR_ATTEMPTS: err_limit  = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned bsize, input int unsigned limit,
                             input int unsigned tries);
        write_reg(CFG_BUFFER_SIZE, bsize[15:0]);
        write_reg(CFG_BAD_BYTE_LIMIT, {8'd0, limit[7:0]});
        write_reg(CFG_ERROR_ATTEMPTS, {12'd0, tries[3:0]});
    endtask

    task automatic add_bytes(input logic [7:0] b[]);
        foreach (b[i])
            pending_words.push_back({1'b0, b[i]});
    endtask

    task automatic add_byte(input logic [7:0] b);
        pending_words.push_back({1'b0, b});
    endtask

    task automatic add_timeout();
        pending_words.push_back({1'b1, 8'($urandom)});
    endtask

    function automatic int unsigned pick_length(input int unsigned hdr,
                                                input int unsigned maxlen);
        int unsigned room;
        int unsigned n;
        room = (cap_bytes > hdr) ? cap_bytes - hdr : 0;
        case ($urandom_range(15))
            0: n = (room <= 40) ? room : $urandom_range(12);
            1: n = room + 1;
            2: n = (maxlen > 255 || $urandom_range(3) == 0) ? maxlen : $urandom_range(12);
            default: n = $urandom_range(12);
        endcase
        if (n > maxlen)
            n = $urandom_range(12);
        return n;
    endfunction

    task automatic add_payload(input int unsigned n);
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic add_command();
        logic [7:0]  code;
        int unsigned n;
        code = 8'($urandom);
        if (code == EVT_ERROR)
            code = 8'h0e;
        n = pick_length(3, 254);
        add_byte(HEADER_BYTE);
        add_byte(code);
        add_byte(n[7:0]);
        add_payload(n);
    endtask

    task automatic add_error_resp();
        int unsigned n;
        n = pick_length(3, 255);
        add_byte(HEADER_BYTE);
        add_byte(EVT_ERROR);
        add_byte(n[7:0]);
        add_payload(n);
    endtask

    // A rejected flash frame is followed by a few stray bytes only, not its
    // whole announced payload.
    task automatic add_flash();
        logic [7:0]  code;
        logic [7:0]  cmd;
        int unsigned n;
        code = 8'($urandom);
        if (code == EVT_ERROR)
            code = 8'hff;
        n = pick_length(9, 65535);
        cmd = ($urandom_range(7) == 0) ? 8'($urandom) : FLASH_CMD_BYTE;
        add_byte(HEADER_BYTE);
        add_byte(code);
        add_byte(LEN_FLASH);
        add_payload(3);
        add_byte(cmd);
        add_byte(n[7:0]);
        add_byte(n[15:8]);
        if (cmd == FLASH_CMD_BYTE && 9 + n <= cap_bytes)
            add_payload(n);
        else
            add_payload($urandom_range(4));
    endtask

    task automatic add_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(3) == 0)
                add_timeout();
            else
            begin
                b = 8'($urandom);
                if (b == HEADER_BYTE && $urandom_range(7) != 0)
                    b = 8'h05;
                add_byte(b);
            end
        end
    endtask

    task automatic add_attempt();
        int unsigned sel;
        int unsigned start;
        int unsigned cut;
        sel = $urandom_range(99);
        start = pending_words.size();
        if (sel < 8)
            add_noise();
        else if (sel < 38)
            add_command();
        else if (sel < 58)
            add_error_resp();
        else if (sel < 88)
            add_flash();
        else
        begin
            if (sel[0])
                add_command();
            else
                add_flash();
            cut = $urandom_range(start + 1, pending_words.size() - 1);
            while (pending_words.size() > cut)
                void'(pending_words.pop_back());
            add_timeout();
        end
    endtask

    task automatic run_random(input int unsigned items);
        int unsigned sent;
        sent = 0;
        while (sent < items)
        begin
            add_attempt();
            sent += pending_words.size();
            send_pending();
        end
    endtask

    task automatic test_defaults_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        add_byte(8'h00);
        pending_words.push_back({1'b1, 8'hff});
        add_bytes('{8'h04, 8'h0e, 8'h02, 8'hff, 8'h00});
        add_bytes('{8'h04, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'hf4, 8'h01, 8'h00, 8'ha5});
        add_bytes('{8'h04, 8'h10, 8'h00});
        add_byte(8'h04);
        add_timeout();
        add_bytes('{8'h04, 8'h0e, 8'h00});
        send_pending();
        end_phase();
    endtask

    task automatic test_register_extremes();
        configure(0, 0, 1);
        add_byte(8'h55);
        add_bytes('{8'h04, 8'h10, 8'h00});
        send_pending();
        end_phase();
        configure(12, 0, 1);
        add_bytes('{8'h04, 8'h10, 8'h00});
        add_bytes('{8'h04, 8'h0e, 8'hff, 8'h00, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00});
        add_bytes('{8'h04, 8'h0e, 8'h0a});
        send_pending();
        end_phase();
        configure(65535, 255, 0);
        add_bytes('{8'h04, 8'h10, 8'h01, 8'h7f});
        add_bytes('{8'h04, 8'h0e, 8'hff, 8'h00, 8'h00, 8'h00, 8'hf4, 8'hff, 8'hff});
        send_pending();
        end_phase();
    endtask

    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                       input int unsigned bsize, input int unsigned limit,
                                       input int unsigned tries, input int unsigned items);
        configure(bsize, limit, tries);
        send_idle_pct = idle;
        stall_pct = stall;
        run_random(items);
        end_phase();
    endtask

    task automatic test_backpressure();
        configure(200, 5, 1);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        run_random(40);
        in_valid <= 1'b0;
        wait_drained();
        send_idle_pct = 11;
        stall_pct = 11;
        run_random(40);
        end_phase();
    endtask

    initial
    begin
        cap_bytes  = BUFFER_SIZE_RST;
        hunt_limit = BAD_BYTE_LIMIT_RST;
        err_limit  = ERROR_ATTEMPTS_RST;
        end_read();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_defaults_directed();
        test_register_extremes();
        test_random_traffic(0, 0, 1024, 50, 3, 120);
        test_random_traffic(70, 0, 65535, 255, 15, 120);
        test_random_traffic(0, 70, 40, 3, 2, 120);
        test_random_traffic(11, 11, $urandom_range(20, 300), $urandom_range(0, 10),
                            $urandom_range(0, 15), 120);
        test_backpressure();

        $display("Run covered %0d input words, %0d result words and %0d finished read attempts,",
                 words_in, words_out, attempts_done);
        $display("over register extremes, idle and stall mixes and a long receiver hold-off.");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/hci_efr_pkg.sv
hw/rtl/hci_efr_parser.sv
hw/rtl/hci_efr_out_buf.sv
hw/rtl/hci_event_frame_receiver_core.sv
sim/tb_top.sv
